### sv/gww_pkg.sv
// ----------------------------------------------------------------------------
// gww_pkg
// Shared types and constants of the greedy word-wrap line breaker.
// ----------------------------------------------------------------------------
package gww_pkg;

  localparam int CharTableDepthDef = 128;
  localparam int PositionBitsDef   = 16;

  localparam int CharCodeBits   = 7;
  localparam int GlyphBits      = 8;
  localparam int SegFieldBits   = 16;
  localparam int LineWidthBits  = 16;
  localparam int RunWidthBits   = 17;
  localparam int CfgIndexBits   = 2;
  localparam int CfgDataBits    = 16;

  localparam logic [CharCodeBits-1:0] SpaceCode   = CharCodeBits'(32);
  localparam logic [CharCodeBits-1:0] NewlineCode = CharCodeBits'(10);

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_CHAR = 2'd1,
    ACT_EOT  = 2'd2
  } action_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_MAX_LINE_WIDTH     = 2'd0,
    CFG_BREAK_INSIDE_WORDS = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [CharCodeBits-1:0] char_code;
    logic [GlyphBits-1:0]    glyph_width;
  } gww_in_t;

  typedef struct packed {
    logic [SegFieldBits-1:0] segment_start;
    logic [SegFieldBits-1:0] segment_length;
    logic                    end_of_text_seen;
  } gww_out_t;

endpackage

### sv/greedy_word_wrap_breaker.sv
// A request is registered in the input stage, and its result is registered in the
// output register once that register is free.
// Throughput: one request per cycle; the input stalls only while the output
// register holds a result that is itself stalled.
// Reset clears positions, widths, the pipeline and the registers to their
// defaults; the glyph width table is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
// greedy_word_wrap_breaker
// Splits a character stream into line segments using a glyph width table.
// ----------------------------------------------------------------------------
module greedy_word_wrap_breaker
  import gww_pkg::*;
#(
  parameter int CHAR_TABLE_DEPTH = CharTableDepthDef,
  parameter int POSITION_BITS    = PositionBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  gww_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output gww_out_t                out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  localparam int TableIdxBits = $clog2(CHAR_TABLE_DEPTH);
  localparam int PosExtBits   = (POSITION_BITS > SegFieldBits) ? POSITION_BITS : SegFieldBits;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [RunWidthBits-1:0]  run_t;
  typedef logic [RunWidthBits:0]    sum_t;

  function automatic run_t sat_add(run_t a, logic [GlyphBits-1:0] b);
    sum_t s;
    s = {1'b0, a} + (RunWidthBits + 1)'(b);
    return s[RunWidthBits] ? {RunWidthBits{1'b1}} : s[RunWidthBits-1:0];
  endfunction

  // Configuration
  logic [LineWidthBits-1:0] max_width_q;
  logic                     break_inside_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q    <= {LineWidthBits{1'b1}};
      break_inside_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MAX_LINE_WIDTH) begin
        max_width_q <= cfg_data_i[LineWidthBits-1:0];
      end
      if (cfg_index_i == CFG_BREAK_INSIDE_WORDS) begin
        break_inside_q <= cfg_data_i[0];
      end
    end
  end

  // Handshake
  logic in_accept;
  logic out_free;
  logic advance;
  logic s1_valid_q;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign advance    = s1_valid_q && out_free;

  // Width table and input stage
  logic [GlyphBits-1:0]    width_mem [CHAR_TABLE_DEPTH];
  logic [TableIdxBits-1:0] mem_idx;
  logic [GlyphBits-1:0]    glyph_q;
  gww_in_t                 s1_item_q;

  assign mem_idx = TableIdxBits'(in_data_i.char_code);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (in_data_i.action == ACT_LOAD) begin
        width_mem[mem_idx] <= in_data_i.glyph_width;
      end
      glyph_q   <= width_mem[mem_idx];
      s1_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Text state
  pos_t stream_q, stream_d;
  pos_t begin_q, begin_d;
  pos_t spos_q, spos_d;
  logic seen_q, seen_d;
  run_t run_q, run_d;
  run_t was_q, was_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q <= '0;
      begin_q  <= '0;
      spos_q   <= '0;
      seen_q   <= 1'b0;
      run_q    <= '0;
      was_q    <= '0;
    end else begin
      stream_q <= stream_d;
      begin_q  <= begin_d;
      spos_q   <= spos_d;
      seen_q   <= seen_d;
      run_q    <= run_d;
      was_q    <= was_d;
    end
  end

  // Per-character terms
  logic is_space, is_newline, is_ctrl;
  pos_t pos_next, len_to_pos, spos_n, spos_plus, len_to_space;
  logic seen_n, overflow, break_at_char;
  run_t was_n;
  sum_t run_sum;

  assign is_space     = s1_item_q.char_code == SpaceCode;
  assign is_newline   = s1_item_q.char_code == NewlineCode;
  assign is_ctrl      = s1_item_q.char_code < SpaceCode;
  assign pos_next     = stream_q + pos_t'(1);
  assign len_to_pos   = stream_q - begin_q;
  assign spos_n       = is_space ? stream_q : spos_q;
  assign seen_n       = is_space || seen_q;
  assign was_n        = is_space ? '0 : sat_add(was_q, glyph_q);
  assign run_sum      = {1'b0, run_q} + (RunWidthBits + 1)'(glyph_q);
  assign overflow     = run_sum > (RunWidthBits + 1)'(max_width_q);
  assign break_at_char = !seen_n || break_inside_q;
  assign spos_plus    = spos_n + pos_t'(1);
  assign len_to_space = spos_plus - begin_q;

  logic res_valid, res_eot;
  pos_t res_start, res_len;

  always_comb begin
    stream_d  = stream_q;
    begin_d   = begin_q;
    spos_d    = spos_q;
    seen_d    = seen_q;
    run_d     = run_q;
    was_d     = was_q;
    res_valid = 1'b0;
    res_eot   = 1'b0;
    res_start = begin_q;
    res_len   = len_to_pos;
    if (advance) begin
      case (s1_item_q.action)
        ACT_EOT: begin
          res_valid = len_to_pos != '0;
          res_eot   = 1'b1;
          stream_d  = '0;
          begin_d   = '0;
          spos_d    = '0;
          seen_d    = 1'b0;
          run_d     = '0;
          was_d     = '0;
        end
        ACT_CHAR: begin
          stream_d = pos_next;
          if (is_newline) begin
            res_valid = len_to_pos != '0;
            begin_d   = pos_next;
            seen_d    = 1'b0;
            run_d     = '0;
            was_d     = '0;
          end else if (!is_ctrl) begin
            spos_d = spos_n;
            seen_d = seen_n;
            was_d  = was_n;
            if (!overflow) begin
              run_d = sat_add(run_q, glyph_q);
            end else begin
              seen_d = 1'b0;
              if (break_at_char) begin
                // overflowing character opens the next segment
                res_valid = len_to_pos != '0;
                begin_d   = stream_q;
                run_d     = RunWidthBits'(glyph_q);
                was_d     = '0;
              end else begin
                // close after the last space, carry the width past it
                res_valid = 1'b1;
                res_len   = len_to_space;
                begin_d   = spos_plus;
                run_d     = was_n;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  logic [PosExtBits-1:0] start_ext, len_ext;
  gww_out_t              out_q;
  logic                  out_valid_q;

  assign start_ext = PosExtBits'(res_start);
  assign len_ext   = PosExtBits'(res_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q.segment_start    <= start_ext[SegFieldBits-1:0];
      out_q.segment_length   <= len_ext[SegFieldBits-1:0];
      out_q.end_of_text_seen <= res_eot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/gww_checker.sv
// ----------------------------------------------------------------------------
// gww_checker
// Port-level checks of the word-wrap breaker, bound to the top level.
// ----------------------------------------------------------------------------
module gww_checker
  import gww_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input gww_out_t out_data_o
);

  // A stalled result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input backs up only behind a full, stalled output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output could drain");

  // A result appearing after an empty output stems from an earlier accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching request");

endmodule

bind greedy_word_wrap_breaker gww_checker u_gww_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy word-wrap line breaker: random text,
// table loads and register settings go in, every segment that comes out is
// checked in order against a cycle-free prediction of the line breaking.
// ----------------------------------------------------------------------------
module tb
  import gww_pkg::*;
();

  localparam logic [1:0] ActReserved = 2'd3;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 6;
  localparam int TimeoutNs   = 4_000_000;

  class segment_scoreboard;
    bit [GlyphBits-1:0]     glyph_px [CharTableDepthDef];
    bit [15:0]              next_pos, seg_begin, space_pos;
    bit                     space_seen;
    bit [RunWidthBits-1:0]  run_width, width_since_space;
    bit [LineWidthBits-1:0] line_limit = 16'hFFFF;
    bit                     split_words;
    gww_out_t               pending_segments[$];
    int unsigned            errors;

    function bit [RunWidthBits-1:0] clamp17(int unsigned v);
      return (v > 32'h1FFFF) ? 17'h1FFFF : RunWidthBits'(v);
    endfunction

    function void set_register(cfg_index_e idx, bit [CfgDataBits-1:0] v);
      if (idx == CFG_MAX_LINE_WIDTH) line_limit = v;
      else if (idx == CFG_BREAK_INSIDE_WORDS) split_words = v[0];
    endfunction

    function void emit(bit [15:0] start, bit [15:0] len, bit eot);
      gww_out_t s;
      s.segment_start    = start;
      s.segment_length   = len;
      s.end_of_text_seen = eot;
      pending_segments.insert(pending_segments.size(), s);
    endfunction

    function void note_request(gww_in_t r);
      bit [15:0]   p, len;
      int unsigned cw;
      p = next_pos;
      case (r.action)
        ACT_LOAD: glyph_px[r.char_code] = r.glyph_width;
        ACT_EOT: begin
          len = next_pos - seg_begin;
          if (len != 0) emit(seg_begin, len, 1'b1);
          next_pos = '0;
          seg_begin = '0;
          space_pos = '0;
          space_seen = 1'b0;
          run_width = '0;
          width_since_space = '0;
        end
        ACT_CHAR: begin
          next_pos = next_pos + 16'd1;
          if (r.char_code == NewlineCode) begin
            len = p - seg_begin;
            if (len != 0) emit(seg_begin, len, 1'b0);
            seg_begin = next_pos;
            space_seen = 1'b0;
            run_width = '0;
            width_since_space = '0;
          end else if (r.char_code >= SpaceCode) begin
            cw = glyph_px[r.char_code];
            if (r.char_code == SpaceCode) begin
              space_pos = p;
              space_seen = 1'b1;
              width_since_space = '0;
            end else begin
              width_since_space = clamp17(width_since_space + cw);
            end
            if (run_width + cw > line_limit) begin
              if (!space_seen || split_words) begin
                // break before the character, which opens the next line
                len = p - seg_begin;
                if (len != 0) emit(seg_begin, len, 1'b0);
                seg_begin = p;
                run_width = RunWidthBits'(cw);
                width_since_space = '0;
              end else begin
                emit(seg_begin, space_pos + 16'd1 - seg_begin, 1'b0);
                seg_begin = space_pos + 16'd1;
                run_width = width_since_space;
              end
              space_seen = 1'b0;
            end else begin
              run_width = clamp17(run_width + cw);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void complain(string field, int unsigned want, int unsigned got);
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_segment(gww_out_t got);
      gww_out_t want;
      if (pending_segments.size() == 0) begin
        $display("%0t: segment expected none got start %0d length %0d eot %0b",
                 $time, got.segment_start, got.segment_length, got.end_of_text_seen);
        errors++;
        return;
      end
      want = pending_segments[0];
      pending_segments.delete(0);
      if (got.segment_start !== want.segment_start)
        complain("segment_start", want.segment_start, got.segment_start);
      if (got.segment_length !== want.segment_length)
        complain("segment_length", want.segment_length, got.segment_length);
      if (got.end_of_text_seen !== want.end_of_text_seen)
        complain("end_of_text_seen", want.end_of_text_seen, got.end_of_text_seen);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  gww_in_t                 in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  gww_out_t                out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_data = '0;

  bit                loaded [CharTableDepthDef];
  bit                tx_quiet, rx_quiet, hold_req;
  segment_scoreboard sb;

  always #2 clk = ~clk;

  greedy_word_wrap_breaker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_segment(out_data);
  end

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [GlyphBits-1:0] pick_glyph();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return GlyphBits'($urandom);
    if (roll < 15) return '0;
    return GlyphBits'($urandom_range(1, 24));
  endfunction

  // only characters whose width entry has been loaded may carry width
  function automatic logic [CharCodeBits-1:0] pick_code();
    int unsigned             roll;
    logic [CharCodeBits-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 5) return NewlineCode;
    if (roll < 8) begin
      c = CharCodeBits'($urandom_range(0, 31));
      return (c == NewlineCode) ? '0 : c;
    end
    if (roll < 26 && loaded[SpaceCode]) return SpaceCode;
    repeat (16) begin
      c = CharCodeBits'($urandom_range(33, 127));
      if (loaded[c]) return c;
    end
    return '0;
  endfunction

  // hold the payload until the request is taken
  task automatic send(gww_in_t r);
    int unsigned g;
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    if (r.action == ACT_LOAD) loaded[r.char_code] = 1'b1;
    g = tx_quiet ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic put_char(logic [CharCodeBits-1:0] c);
    gww_in_t r;
    r.action = ACT_CHAR;
    r.char_code = c;
    r.glyph_width = GlyphBits'($urandom);
    send(r);
  endtask

  task automatic load_glyph(logic [CharCodeBits-1:0] c, logic [GlyphBits-1:0] w);
    gww_in_t r;
    r.action = ACT_LOAD;
    r.char_code = c;
    r.glyph_width = w;
    send(r);
  endtask

  task automatic end_text();
    gww_in_t r;
    r.action = ACT_EOT;
    r.char_code = CharCodeBits'($urandom);
    r.glyph_width = GlyphBits'($urandom);
    send(r);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) put_char(CharCodeBits'(s[i]));
  endtask

  task automatic random_burst(int unsigned count, bit with_eot);
    int unsigned done;
    int unsigned roll;
    gww_in_t     r;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      r.char_code = CharCodeBits'($urandom);
      r.glyph_width = GlyphBits'($urandom);
      if (roll < 4) begin
        r.action = ACT_LOAD;
        r.glyph_width = pick_glyph();
      end else if (roll < 7 && with_eot) begin
        r.action = ACT_EOT;
      end else if (roll < 9) begin
        r.action = ActReserved;
      end else begin
        r.action = ACT_CHAR;
        r.char_code = pick_code();
      end
      send(r);
      if (r.action != ActReserved) done++;
    end
  endtask

  // drop valid and let every expected segment come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_segments.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CfgDataBits-1:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [LineWidthBits-1:0] limit, logic split);
    drain();
    write_reg(CFG_MAX_LINE_WIDTH, limit);
    write_reg(CFG_BREAK_INSIDE_WORDS, CfgDataBits'(split));
  endtask

  initial begin : rx_side
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = rx_quiet ? 0 : idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat (rx_quiet ? 1 : $urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    gww_in_t odd;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(16'd50, 1'b0);
    load_glyph(SpaceCode, 8'd5);
    load_glyph(7'd97, 8'd10);
    load_glyph(7'd65, 8'd0);
    load_glyph(7'd127, 8'd255);
    send_string("aa aa a");
    put_char(7'd0);
    put_char(7'd31);
    send_string("\n\n");
    // wider than the limit on an empty line: opens the line alone
    put_char(7'd127);
    send_string("aA");
    end_text();
    end_text();
    odd.action = ActReserved;
    odd.char_code = 7'h7F;
    odd.glyph_width = 8'hFF;
    send(odd);
    configure(16'd0, 1'b1);
    send_string("a Aa a");
    end_text();

    for (int c = SpaceCode; c < CharTableDepthDef; c++)
      load_glyph(CharCodeBits'(c), pick_glyph());

    configure(16'd120, 1'b0);
    random_burst(150, 1'b1);
    configure(16'd120, 1'b1);
    random_burst(150, 1'b1);

    // stall the output for a long stretch while requests keep coming
    configure(16'd300, 1'b0);
    hold_req = 1'b1;
    tx_quiet = 1'b1;
    random_burst(120, 1'b1);
    tx_quiet = 1'b0;
    random_burst(30, 1'b1);
    drain();
    random_burst(100, 1'b1);

    configure(16'd0, 1'b0);
    random_burst(100, 1'b1);
    configure(16'hFFFF, 1'b1);
    random_burst(100, 1'b1);
    configure(16'd60, 1'b1);
    rx_quiet = 1'b1;
    tx_quiet = 1'b1;
    random_burst(100, 1'b1);
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    configure(LineWidthBits'($urandom_range(20, 600)), 1'($urandom));
    random_burst(150, 1'b1);
    end_text();

    drain();
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
